@@ rtl/keyed_ordered_list_with_cursor_unit_assert.svh @@
// Assertion macros for the keyed ordered list unit.
// Used by the top level only; empty bodies when SYNTHESIS is defined.
`ifndef KEYED_ORDERED_LIST_WITH_CURSOR_UNIT_ASSERT_SVH
`define KEYED_ORDERED_LIST_WITH_CURSOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define KOLC_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define KOLC_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define KOLC_ASSERT(name, clk, rst, prop, msg)
`define KOLC_ASSERT_NEXT(name, clk, rst, pre, post, msg)
`endif
`endif

@@ rtl/kolc_pkg.sv @@
// Shared types and codes for the keyed ordered list unit.
// No dependencies.
`default_nettype none
package kolc_pkg;
  localparam logic [2:0] MODE_APPEND  = 3'd0;
  localparam logic [2:0] MODE_REMOVE  = 3'd1;
  localparam logic [2:0] MODE_FWD     = 3'd2;
  localparam logic [2:0] MODE_BACK    = 3'd3;
  localparam logic [2:0] MODE_ADVANCE = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DUP       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NO_NEXT   = 3'd3;
  localparam logic [2:0] ST_NO_PREV   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  localparam int StepWidth = 7;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_EXEC = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

  typedef struct packed {
    logic compare;
    logic write;
    logic shift;
  } cell_ctl_t;
endpackage
`default_nettype wire

@@ rtl/kolc_cell.sv @@
// One list position: key, valid bit and lookup hit.
// Depends on kolc_pkg for the control struct.
`default_nettype none
module kolc_cell #(
  parameter int KW = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  kolc_pkg::cell_ctl_t  ctl,
  input  wire [KW-1:0]         cmp_key,
  input  wire [KW-1:0]         right_key,
  input  wire                  right_valid,
  output logic [KW-1:0]        key,
  output logic                 valid,
  output logic                 hit
);
  always_ff @(posedge clk) begin
    if (ctl.write) begin
      key <= cmp_key;
    end else if (ctl.shift) begin
      key <= right_key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      hit   <= 1'b0;
    end else begin
      if (ctl.compare) begin
        hit <= valid && (key == cmp_key);
      end
      if (ctl.write) begin
        valid <= 1'b1;
      end else if (ctl.shift) begin
        // take the neighbor's entry to close the gap
        valid <= right_valid;
      end
    end
  end
endmodule
`default_nettype wire

@@ rtl/keyed_ordered_list_with_cursor_unit.sv @@
// Keyed ordered list with cursor, held as a row of cells in list order.
// A request is accepted in idle; then lookup compare in all cells, execute
// (write or left shift of the row), cursor key select into the output
// register. A result that waits for m_tready holds the unit. One request
// in flight; a new request is accepted only back in idle.
// Synchronous active-high reset empties the list.
`default_nettype none
`include "keyed_ordered_list_with_cursor_unit_assert.svh"
module keyed_ordered_list_with_cursor_unit #(
  parameter int CAPACITY  = 64,
  parameter int KEY_WIDTH = 16
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_tvalid,
  output logic             s_tready,
  // mode[2:0], entry_key, step_count, zero pad
  input  wire [((3+KEY_WIDTH+kolc_pkg::StepWidth+7)/8)*8-1:0] s_tdata,
  output logic             m_tvalid,
  input  wire              m_tready,
  // status[2:0], cursor_key, cursor_valid, entry_count, zero pad
  output logic [((4+KEY_WIDTH+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_tdata
);
  localparam int KW     = KEY_WIDTH;
  localparam int SW     = kolc_pkg::StepWidth;
  localparam int IW     = $clog2(CAPACITY);
  localparam int CW     = $clog2(CAPACITY + 1);
  localparam int AW     = CW + SW + 1;
  localparam int OUT_W  = ((4 + KW + CW + 7) / 8) * 8;
  localparam int OUT_B  = 4 + KW + CW;

  kolc_pkg::state_t state;
  logic [2:0]    cmd_mode;
  logic [KW-1:0] cmd_key;
  logic [SW-1:0] cmd_steps;
  logic [CW-1:0] count;
  logic [IW-1:0] cur;
  logic          cur_valid;
  logic [2:0]    status;

  logic [KW-1:0] cell_key [CAPACITY];
  logic          cell_valid [CAPACITY];
  logic          cell_hit [CAPACITY];
  kolc_pkg::cell_ctl_t cell_ctl [CAPACITY];

  logic          hit_any;
  logic [IW-1:0] hit_pos;
  logic [2:0]    status_next;
  logic [CW-1:0] count_next;
  logic [IW-1:0] cur_next;
  logic          cur_valid_next;
  logic          do_write;
  logic          do_shift;
  logic [KW-1:0] sel_key;

  assign s_tready = (state == kolc_pkg::S_IDLE);

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      localparam logic [IW-1:0] POS = IW'(g);
      logic [KW-1:0] rk;
      logic          rv;
      if (g == CAPACITY - 1) begin : g_end
        assign rk = '0;
        assign rv = 1'b0;
      end else begin : g_mid
        assign rk = cell_key[g+1];
        assign rv = cell_valid[g+1];
      end
      always_comb begin
        cell_ctl[g].compare = (state == kolc_pkg::S_LOOK);
        cell_ctl[g].write   = do_write && (count == CW'(g));
        cell_ctl[g].shift   = do_shift && (POS >= hit_pos);
      end
      kolc_cell #(.KW(KW)) u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (cell_ctl[g]),
        .cmp_key    (cmd_key),
        .right_key  (rk),
        .right_valid(rv),
        .key        (cell_key[g]),
        .valid      (cell_valid[g]),
        .hit        (cell_hit[g])
      );
    end
  endgenerate

  // keys are unique, so at most one hit; OR the positions together
  always_comb begin
    hit_any = 1'b0;
    hit_pos = '0;
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_any = hit_any | cell_hit[i];
      hit_pos = hit_pos | (IW'(i) & {IW{cell_hit[i]}});
      sel_key = sel_key | (cell_key[i] & {KW{cell_valid[i] && (cur == IW'(i))}});
    end
  end

  always_comb begin
    logic [AW-1:0] cur_w;
    logic [AW-1:0] cnt_w;
    logic [AW-1:0] pos_w;
    logic [AW-1:0] tgt;
    cur_w          = AW'(cur);
    cnt_w          = AW'(count);
    pos_w          = AW'(hit_pos);
    tgt            = cur_w + AW'(cmd_steps);
    status_next    = kolc_pkg::ST_OK;
    count_next     = count;
    cur_next       = cur;
    cur_valid_next = cur_valid;
    do_write       = 1'b0;
    do_shift       = 1'b0;
    if (state == kolc_pkg::S_EXEC) begin
      unique case (cmd_mode)
        kolc_pkg::MODE_APPEND: begin
          if (hit_any) begin
            status_next = kolc_pkg::ST_DUP;
          end else if (cnt_w == AW'(CAPACITY)) begin
            status_next = kolc_pkg::ST_FULL;
          end else begin
            do_write   = 1'b1;
            count_next = count + CW'(1);
            if (!cur_valid) begin
              cur_next       = '0;
              cur_valid_next = 1'b1;
            end
          end
        end
        kolc_pkg::MODE_REMOVE: begin
          if (!hit_any) begin
            status_next = kolc_pkg::ST_NOT_FOUND;
          end else begin
            do_shift   = 1'b1;
            count_next = count - CW'(1);
            if (cur == hit_pos) begin
              // successor slides into this position; else fall back
              if (pos_w + AW'(1) < cnt_w) begin
                cur_next = cur;
              end else if (hit_pos != '0) begin
                cur_next = hit_pos - IW'(1);
              end else begin
                cur_valid_next = 1'b0;
              end
            end else if (cur > hit_pos) begin
              cur_next = cur - IW'(1);
            end
          end
        end
        kolc_pkg::MODE_FWD: begin
          if (cur_valid && (cur_w + AW'(1) < cnt_w)) begin
            cur_next = cur + IW'(1);
          end else begin
            status_next = kolc_pkg::ST_NO_NEXT;
          end
        end
        kolc_pkg::MODE_BACK: begin
          if (cur_valid && (cur != '0)) begin
            cur_next = cur - IW'(1);
          end else begin
            status_next = kolc_pkg::ST_NO_PREV;
          end
        end
        kolc_pkg::MODE_ADVANCE: begin
          if (!cur_valid) begin
            status_next = kolc_pkg::ST_EMPTY;
          end else if (tgt > cnt_w - AW'(1)) begin
            cur_next = IW'(cnt_w - AW'(1));
          end else begin
            cur_next = IW'(tgt);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cmd_mode  <= s_tdata[2:0];
      cmd_key   <= s_tdata[3 +: KW];
      cmd_steps <= s_tdata[3+KW +: SW];
    end
    if (state == kolc_pkg::S_EXEC) begin
      status <= status_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= kolc_pkg::S_IDLE;
      count     <= '0;
      cur       <= '0;
      cur_valid <= 1'b0;
      m_tvalid  <= 1'b0;
      m_tdata   <= '0;
    end else begin
      if (m_tvalid && m_tready && (state != kolc_pkg::S_RESP)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        kolc_pkg::S_IDLE: begin
          if (s_tvalid) begin
            state <= kolc_pkg::S_LOOK;
          end
        end
        kolc_pkg::S_LOOK: begin
          state <= kolc_pkg::S_EXEC;
        end
        kolc_pkg::S_EXEC: begin
          count     <= count_next;
          cur       <= cur_next;
          cur_valid <= cur_valid_next;
          state     <= kolc_pkg::S_RESP;
        end
        kolc_pkg::S_RESP: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({count, cur_valid,
                                sel_key & {KW{cur_valid}}, status});
            state    <= kolc_pkg::S_IDLE;
          end
        end
        default: begin
          state <= kolc_pkg::S_IDLE;
        end
      endcase
    end
  end

  `KOLC_ASSERT(a_count_bound, clk, rst, count <= CW'(CAPACITY), "count exceeds capacity")
  `KOLC_ASSERT(a_cursor_count, clk, rst, cur_valid == (count != '0), "cursor and count disagree")
  `KOLC_ASSERT_NEXT(a_accept_look, clk, rst, s_tvalid && s_tready, state == kolc_pkg::S_LOOK, "accept not followed by lookup")
  `KOLC_ASSERT_NEXT(a_exec_resp, clk, rst, state == kolc_pkg::S_EXEC, state == kolc_pkg::S_RESP, "execute not followed by response")

  logic unused_pad;
  assign unused_pad = ^{s_tdata, OUT_B[0]};
endmodule
`default_nettype wire
